// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/tpd_pkg.sv -----
`default_nettype none

package tpd_pkg;

  localparam int FULL_SCALE = 4096;

  localparam int BYTE_W  = 8;
  localparam int RAW_W   = 15;
  localparam int DIM_W   = 16;
  localparam int POS_W   = 16;
  localparam int COUNT_W = 16;
  localparam int SCALE_W = $clog2(FULL_SCALE + 1);
  localparam int PROD_W  = RAW_W + SCALE_W;
  localparam int ITER_W  = $clog2(PROD_W + 1);

  localparam logic [BYTE_W-1:0] HDR_TOUCH   = 8'hC0;
  localparam logic [BYTE_W-1:0] HDR_RELEASE = 8'h80;
  localparam logic [BYTE_W-1:0] REPLY_START = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
  localparam int               TOUCH_BIT   = 6;

  localparam logic [COUNT_W-1:0] ELAPSED_MAX       = '1;
  localparam logic [COUNT_W-1:0] BLINK_LIMIT_RESET = 16'd5;
  localparam logic [COUNT_W-1:0] WAIT_MS_RESET     = 16'd300;
  localparam logic [DIM_W-1:0]   WIDTH_RESET       = 16'd1024;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET      = 16'd768;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [2:0] REG_DRAG_MODE    = 3'd0;
  localparam logic [2:0] REG_BLINK_LIMIT  = 3'd1;
  localparam logic [2:0] REG_WAIT_MS      = 3'd2;
  localparam logic [2:0] REG_PANEL_WIDTH  = 3'd3;
  localparam logic [2:0] REG_PANEL_HEIGHT = 3'd4;

  typedef enum logic [1:0] {
    ITEM_BYTE = 2'b01,
    ITEM_TICK = 2'b10
  } item_kind_t;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    logic             pressed;
  } result_t;

  typedef struct packed {
    logic               drag_mode;
    logic [COUNT_W-1:0] blink_limit;
    logic [COUNT_W-1:0] wait_ms;
  } filter_cfg_t;

  typedef struct packed {
    logic              fire;
    logic              touch;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
    logic [BYTE_W-1:0] b4;
  } packet_t;

endpackage

`default_nettype wire

// ----- src/tpd_parser.sv -----
`default_nettype none

module tpd_parser (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       accept,
  input  wire tpd_pkg::item_t       item,
  input  wire tpd_pkg::filter_cfg_t cfg,
  output tpd_pkg::packet_t          pkt
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_TOUCH = 3'b010,
    PH_REPLY = 3'b100
  } phase_t;

  phase_t                        phase, phase_next;
  logic [1:0]                    byte_index, byte_index_next;
  logic [tpd_pkg::BYTE_W-1:0]    b1, b2, b3;
  logic                          header_touch, header_touch_next;
  logic                          saw_cr, saw_cr_next;
  logic                          last_action, last_action_next;
  logic [tpd_pkg::COUNT_W-1:0]   blink_count, blink_count_next;
  logic [tpd_pkg::COUNT_W-1:0]   elapsed_ms, elapsed_ms_next;
  logic                          fire;
  logic [tpd_pkg::BYTE_W-1:0]    b;
  tpd_pkg::item_kind_t           kind;

  assign b    = item.data_byte;
  assign kind = item.cmd ? tpd_pkg::ITEM_TICK : tpd_pkg::ITEM_BYTE;

  always_comb begin
    phase_next        = phase;
    byte_index_next   = byte_index;
    header_touch_next = header_touch;
    saw_cr_next       = saw_cr;
    last_action_next  = last_action;
    blink_count_next  = blink_count;
    elapsed_ms_next   = elapsed_ms;
    fire              = 1'b0;
    if (accept) begin
      unique case (kind)
        tpd_pkg::ITEM_TICK: begin
          if (elapsed_ms != tpd_pkg::ELAPSED_MAX) begin
            elapsed_ms_next = elapsed_ms + 1'b1;
          end
        end
        tpd_pkg::ITEM_BYTE: begin
          unique case (phase)
            PH_REPLY: begin
              if (b == tpd_pkg::CHAR_LF && saw_cr) begin
                phase_next = PH_IDLE;
              end
              saw_cr_next = (b == tpd_pkg::CHAR_CR);
            end
            PH_IDLE: begin
              if (b == tpd_pkg::HDR_TOUCH || b == tpd_pkg::HDR_RELEASE) begin
                phase_next        = PH_TOUCH;
                byte_index_next   = 2'd0;
                header_touch_next = b[tpd_pkg::TOUCH_BIT];
              end else if (b == tpd_pkg::REPLY_START) begin
                phase_next  = PH_REPLY;
                saw_cr_next = 1'b0;
              end
            end
            PH_TOUCH: begin
              if (byte_index != 2'd3) begin
                byte_index_next = byte_index + 2'd1;
              end else begin
                phase_next      = PH_IDLE;
                byte_index_next = 2'd0;
                if (!cfg.drag_mode && last_action == header_touch) begin
                  blink_count_next = '0;
                end else if (header_touch && blink_count < cfg.blink_limit &&
                             elapsed_ms < cfg.wait_ms) begin
                  blink_count_next = blink_count + 1'b1;
                  elapsed_ms_next  = '0;
                end else begin
                  blink_count_next = '0;
                  last_action_next = header_touch;
                  elapsed_ms_next  = '0;
                  fire             = 1'b1;
                end
              end
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_index   <= 2'd0;
      header_touch <= 1'b0;
      saw_cr       <= 1'b0;
      last_action  <= 1'b0;
      blink_count  <= '0;
      elapsed_ms   <= tpd_pkg::ELAPSED_MAX;
    end else begin
      phase        <= phase_next;
      byte_index   <= byte_index_next;
      header_touch <= header_touch_next;
      saw_cr       <= saw_cr_next;
      last_action  <= last_action_next;
      blink_count  <= blink_count_next;
      elapsed_ms   <= elapsed_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !item.cmd && phase == PH_TOUCH) begin
      unique case (byte_index)
        2'd0:    b1 <= b;
        2'd1:    b2 <= b;
        2'd2:    b3 <= b;
        default: b3 <= b3;
      endcase
    end
  end

  assign pkt.fire  = fire;
  assign pkt.touch = header_touch;
  assign pkt.b1    = b1;
  assign pkt.b2    = b2;
  assign pkt.b3    = b3;
  assign pkt.b4    = b;

endmodule

`default_nettype wire

// ----- src/tpd_div.sv -----
`default_nettype none

module tpd_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [tpd_pkg::RAW_W-1:0]     raw,
  input  wire [tpd_pkg::DIM_W-1:0]     dim,
  output logic                         busy,
  output logic [tpd_pkg::POS_W-1:0]    quot
);

  localparam int PW = tpd_pkg::PROD_W;
  localparam int DW = tpd_pkg::DIM_W;

  logic [PW-1:0]               acc, acc_next;
  logic [DW-1:0]               rem, rem_next;
  logic [DW-1:0]               divisor;
  logic [tpd_pkg::ITER_W-1:0]  iter;
  logic [DW:0]                 rem_sh;
  logic [DW+1:0]               diff;
  logic                        ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh   = {rem, acc[PW-1]};
    diff     = {1'b0, rem_sh} - {2'b00, divisor};
    ge       = ~diff[DW+1];
    rem_next = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
    acc_next = {acc[PW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= tpd_pkg::ITER_W'(PW);
    end else if (busy) begin
      iter <= iter - 1'b1;
      busy <= (iter != tpd_pkg::ITER_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc     <= PW'(raw) * PW'(tpd_pkg::FULL_SCALE);
      rem     <= '0;
      divisor <= dim;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign quot = (|acc[PW-1:tpd_pkg::POS_W]) ? '1 : acc[tpd_pkg::POS_W-1:0];

endmodule

`default_nettype wire

// ----- src/touch_packet_decoder_filter_top.sv -----
// touch packet decoder and event filter
//
// item channel (item_valid, item_stall, item): cmd 0 carries a received serial
// byte in data_byte, cmd 1 is a one millisecond tick. a transfer happens on a
// rising edge with item_valid high and item_stall low.
// result channel (result_valid, result_stall, result): one touch or release
// event with scaled x_pos and y_pos, taken on an edge with result_stall low.
// ticks and all other bytes leave item_stall low. the byte that completes a touch packet
// and passes the filter starts two bit-serial dividers, one quotient bit per
// cycle over the 28-bit scaled raw word; once both end, the result is loaded
// into the output register and result_valid rises. item_stall stays high
// until that load. the next item may be taken while the result waits.
// if result_stall holds the output register full when a division ends,
// item_stall stays high until the result moves out.
// registers sit on the apb port at byte offsets 0, 4, 8, 12, 16; writes are
// meant only while the block is idle. rst clears the parser, the filter,
// the registers to their defaults and the output register.
`default_nettype none

module touch_packet_decoder_filter_top (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              item_valid,
  output logic                             item_stall,
  input  wire tpd_pkg::item_t              item,
  output logic                             result_valid,
  input  wire                              result_stall,
  output tpd_pkg::result_t                 result,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [tpd_pkg::ADDR_W-1:0]        paddr,
  input  wire [tpd_pkg::DATA_W-1:0]        pwdata,
  output logic [tpd_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_DIVIDE = 2'b10
  } state_t;

  state_t                        state, state_next;
  tpd_pkg::filter_cfg_t          cfg;
  logic [tpd_pkg::DIM_W-1:0]     panel_width;
  logic [tpd_pkg::DIM_W-1:0]     panel_height;
  tpd_pkg::packet_t              pkt;
  logic                          item_accept;
  logic                          start;
  logic                          x_busy, y_busy;
  logic [tpd_pkg::POS_W-1:0]     x_quot, y_quot;
  logic [tpd_pkg::RAW_W-1:0]     x_raw, y_raw;
  logic                          pressed;
  logic                          out_free;
  logic                          load;
  logic [2:0]                    reg_index;
  logic                          reg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[tpd_pkg::ADDR_W-1:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drag_mode   <= 1'b0;
      cfg.blink_limit <= tpd_pkg::BLINK_LIMIT_RESET;
      cfg.wait_ms     <= tpd_pkg::WAIT_MS_RESET;
      panel_width     <= tpd_pkg::WIDTH_RESET;
      panel_height    <= tpd_pkg::HEIGHT_RESET;
    end else if (reg_write) begin
      unique case (reg_index)
        tpd_pkg::REG_DRAG_MODE:    cfg.drag_mode   <= pwdata[0];
        tpd_pkg::REG_BLINK_LIMIT:  cfg.blink_limit <= pwdata[tpd_pkg::COUNT_W-1:0];
        tpd_pkg::REG_WAIT_MS:      cfg.wait_ms     <= pwdata[tpd_pkg::COUNT_W-1:0];
        tpd_pkg::REG_PANEL_WIDTH:  panel_width     <= pwdata[tpd_pkg::DIM_W-1:0];
        tpd_pkg::REG_PANEL_HEIGHT: panel_height    <= pwdata[tpd_pkg::DIM_W-1:0];
        default:                   panel_height    <= panel_height;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      tpd_pkg::REG_DRAG_MODE:    prdata = tpd_pkg::DATA_W'(cfg.drag_mode);
      tpd_pkg::REG_BLINK_LIMIT:  prdata = tpd_pkg::DATA_W'(cfg.blink_limit);
      tpd_pkg::REG_WAIT_MS:      prdata = tpd_pkg::DATA_W'(cfg.wait_ms);
      tpd_pkg::REG_PANEL_WIDTH:  prdata = tpd_pkg::DATA_W'(panel_width);
      tpd_pkg::REG_PANEL_HEIGHT: prdata = tpd_pkg::DATA_W'(panel_height);
      default:                   prdata = '0;
    endcase
  end

  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;

  tpd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (item_accept),
    .item   (item),
    .cfg    (cfg),
    .pkt    (pkt)
  );

  assign start = pkt.fire;
  assign x_raw = {pkt.b2, 7'b0} | tpd_pkg::RAW_W'(pkt.b1);
  assign y_raw = {pkt.b4, 7'b0} | tpd_pkg::RAW_W'(pkt.b3);

  tpd_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .raw   (x_raw),
    .dim   (panel_width),
    .busy  (x_busy),
    .quot  (x_quot)
  );

  tpd_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .raw   (y_raw),
    .dim   (panel_height),
    .busy  (y_busy),
    .quot  (y_quot)
  );

  always_ff @(posedge clk) begin
    if (start) begin
      pressed <= pkt.touch;
    end
  end

  assign out_free = !result_valid || !result_stall;
  assign load     = (state == ST_DIVIDE) && !x_busy && !y_busy && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_DIVIDE;
      ST_DIVIDE: if (load)  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.x_pos   <= x_quot;
      result.y_pos   <= y_quot;
      result.pressed <= pressed;
    end
  end

endmodule

`default_nettype wire

// ----- src/tpd_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module tpd_checker (
  input wire                         clk,
  input wire                         rst,
  input wire                         item_valid,
  input wire                         item_stall,
  input wire tpd_pkg::item_t         item,
  input wire                         result_valid,
  input wire                         result_stall,
  input wire tpd_pkg::result_t       result,
  input wire                         psel,
  input wire                         penable,
  input wire                         pwrite,
  input wire [tpd_pkg::ADDR_W-1:0]   paddr,
  input wire [tpd_pkg::DATA_W-1:0]   pwdata,
  input wire [tpd_pkg::DATA_W-1:0]   prdata,
  input wire                         pready
);

  logic item_unused;
  logic cfg_unused;

  assign item_unused = item_valid ^ (^item);
  assign cfg_unused  = psel ^ penable ^ pwrite ^ (^paddr) ^ (^pwdata) ^ (^prdata) ^ pready;

  // a stalled result holds
  `ASSERT_CLK(a_result_hold, clk, rst, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

  // reset empties the output register
  `ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !result_valid, "result valid after reset")

  // a new result only comes out of a division, during which items are held off
  `ASSERT_CLK(a_result_after_div, clk, rst, $rose(result_valid) |-> $past(item_stall) && $past(item_stall, 2), "result without division")

endmodule

bind touch_packet_decoder_filter_top tpd_checker u_tpd_checker (.*);

`default_nettype wire
